// ----- rtl/core/gps_pkg.sv -----
`timescale 1ns / 1ps

package gps_pkg;

    localparam int COEFF_COUNT     = 5;
    localparam int STEP_RANGE_HALF = 32767;
    localparam int STEP_MAX        = 32767;
    localparam int STEP_MIN        = -32768;

    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    localparam logic [1:0] CFG_SCALE_X  = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y  = 2'd1;
    localparam logic [1:0] CFG_OFFSET_X = 2'd2;
    localparam logic [1:0] CFG_OFFSET_Y = 2'd3;

    localparam logic signed [65:0] ACC_HI = 66'sd140737488355327;
    localparam logic signed [65:0] ACC_LO = -66'sd140737488355328;

    localparam logic signed [34:0] POS_HI = 35'sd2147483647;
    localparam logic signed [34:0] POS_LO = -35'sd2147483648;

    localparam logic [14:0] STEP_K = 15'(STEP_RANGE_HALF);
    localparam logic signed [63:0] ROUND_C = 64'sd671088640;

    // quotient bound: beyond it the step clamps whatever the offset
    localparam logic signed [35:0] M_HI   = 36'sd655359;
    localparam logic signed [35:0] M_LO   = -36'sd655360;
    localparam logic signed [35:0] M_BIAS = 36'sd655360;
    localparam logic [21:0] DIV_R     = 22'd3355444;
    localparam logic signed [19:0] Q_BIAS = 20'sd131072;

    localparam logic signed [20:0] STEP_HI = 21'(STEP_MAX);
    localparam logic signed [20:0] STEP_LO = 21'(STEP_MIN);

    typedef struct packed {
        logic               valid;
        logic               mode;
        logic [1:0]         set;
        logic [2:0]         slot;
        logic signed [31:0] cvalue;
        logic signed [31:0] p;
        logic signed [47:0] acc;
    } t_item;

    typedef struct packed {
        logic valid;
        logic mode;
        logic axis;
    } t_ctl;

endpackage

// ----- rtl/core/galvo_position_to_step.sv -----
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                      | Payload
// s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | tdata, tuser: request
// m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | tdata, tuser: step result
// cfg      | in        | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One request per cycle while the chain is not held; a request passes the front stages,
// the Horner cell chain (two register stages per coefficient cell) and the back end.
// Reset clears the coefficient table in every cell and loads the default scales and offsets.
// The whole chain holds only while the output register is full, not taken, and the
// last back-end stage carries a request; bubbles still advance and let requests in.

module galvo_position_to_step import gps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] position, [34:32] coeff_index, [66:35] coeff_value, [71:67] zero
    input  logic [71:0] i_s_axis_tdata,
    // [0] mode, [1] use_y_axis, [2] use_cornea
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] step
    output logic [15:0] o_m_axis_tdata,
    // [0] saturated
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data
);

    logic [17:0]        r_scale_x;
    logic [17:0]        r_scale_y;
    logic signed [15:0] r_offset_x;
    logic signed [15:0] r_offset_y;
    logic               w_en;
    logic signed [15:0] w_step;
    logic               w_sat;
    t_item              w_chain [COEFF_COUNT + 1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= 18'd65536;
            r_scale_y  <= 18'd65536;
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCALE_X:  r_scale_x  <= i_cfg_data;
                CFG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                CFG_OFFSET_X: r_offset_x <= i_cfg_data[15:0];
                CFG_OFFSET_Y: r_offset_y <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    gps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_axis_tvalid),
        .i_mode        (i_s_axis_tuser[0]),
        .i_position    (i_s_axis_tdata[31:0]),
        .i_use_y_axis  (i_s_axis_tuser[1]),
        .i_use_cornea  (i_s_axis_tuser[2]),
        .i_coeff_index (i_s_axis_tdata[34:32]),
        .i_coeff_value (i_s_axis_tdata[66:35]),
        .i_scale_x     (r_scale_x),
        .i_scale_y     (r_scale_y),
        .o_item        (w_chain[0])
    );

    for (genvar k = 0; k < COEFF_COUNT; k++) begin : g_cell
        gps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_slot  (3'(k)),
            .i_item  (w_chain[k]),
            .o_item  (w_chain[k + 1])
        );
    end

    gps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_chain[COEFF_COUNT]),
        .i_offset_x  (r_offset_x),
        .i_offset_y  (r_offset_y),
        .i_m_ready   (i_m_axis_tready),
        .o_en        (w_en),
        .o_valid     (o_m_axis_tvalid),
        .o_step      (w_step),
        .o_saturated (w_sat)
    );

    assign o_s_axis_tready   = w_en;
    assign o_m_axis_tdata    = w_step;
    assign o_m_axis_tuser[0] = w_sat;

endmodule

// ----- rtl/core/gps_front.sv -----
`timescale 1ns / 1ps

module gps_front import gps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_mode,
    input  logic signed [31:0] i_position,
    input  logic               i_use_y_axis,
    input  logic               i_use_cornea,
    input  logic [2:0]         i_coeff_index,
    input  logic signed [31:0] i_coeff_value,
    input  logic [17:0]        i_scale_x,
    input  logic [17:0]        i_scale_y,
    output t_item              o_item
);

    t_item                r_f1;
    t_item                r_f2;
    logic signed [50:0]   r_prod;
    logic [17:0]          w_scale;
    logic signed [34:0]   w_sh;
    t_item                n_f1;
    t_item                n_f2;

    assign w_scale = i_use_y_axis ? i_scale_y : i_scale_x;
    assign w_sh    = $signed(r_prod[50:16]);

    always_comb begin
        n_f1        = '0;
        n_f1.valid  = i_valid;
        n_f1.mode   = i_mode;
        n_f1.set    = {i_use_y_axis, i_use_cornea};
        n_f1.slot   = i_coeff_index;
        n_f1.cvalue = i_coeff_value;
    end

    always_comb begin
        n_f2 = r_f1;
        if (w_sh > POS_HI) begin
            n_f2.p = POS_HI[31:0];
        end else if (w_sh < POS_LO) begin
            n_f2.p = POS_LO[31:0];
        end else begin
            n_f2.p = w_sh[31:0];
        end
        n_f2.acc = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.valid <= 1'b0;
            r_f2.valid <= 1'b0;
        end else if (i_en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed(i_position) * $signed({1'b0, w_scale});
        end
    end

    assign o_item = r_f2;

endmodule

// ----- rtl/core/gps_cell.sv -----
`timescale 1ns / 1ps

module gps_cell import gps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [2:0] i_slot,
    input  t_item      i_item,
    output t_item      o_item
);

    t_item              r_a;
    t_item              r_b;
    logic signed [63:0] r_hp;
    logic signed [48:0] r_lp;
    logic signed [31:0] r_coef [4];
    logic signed [31:0] w_coef;
    logic signed [65:0] w_sum;
    t_item              n_b;

    assign w_coef = r_coef[r_a.set];
    assign w_sum  = {{2{r_hp[63]}}, r_hp} + {{33{r_lp[48]}}, r_lp[48:16]}
                  + {{34{w_coef[31]}}, w_coef};

    always_comb begin
        n_b = r_a;
        if (w_sum > ACC_HI) begin
            n_b.acc = ACC_HI[47:0];
        end else if (w_sum < ACC_LO) begin
            n_b.acc = ACC_LO[47:0];
        end else begin
            n_b.acc = w_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            for (int s = 0; s < 4; s++) begin
                r_coef[s] <= '0;
            end
        end else if (i_en) begin
            r_a <= i_item;
            r_b <= n_b;
            if (r_a.valid && r_a.mode == MODE_WRITE && r_a.slot == i_slot) begin
                r_coef[r_a.set] <= r_a.cvalue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hp <= $signed(i_item.acc[47:16]) * $signed(i_item.p);
            r_lp <= $signed({1'b0, i_item.acc[15:0]}) * $signed(i_item.p);
        end
    end

    assign o_item = r_b;

endmodule

// ----- rtl/core/gps_back.sv -----
`timescale 1ns / 1ps

module gps_back import gps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic               i_m_ready,
    output logic               o_en,
    output logic               o_valid,
    output logic signed [15:0] o_step,
    output logic               o_saturated
);

    t_ctl               r_e1;
    t_ctl               r_e2;
    t_ctl               r_e3;
    logic signed [47:0] r_hk;
    logic [30:0]        r_lk;
    logic [20:0]        r_u;
    logic [42:0]        r_ur;
    logic               r_out_valid;
    logic signed [15:0] r_step;
    logic               r_sat;
    t_ctl               n_e1;
    logic signed [63:0] w_n;
    logic signed [35:0] w_m;
    logic signed [35:0] w_mc;
    logic signed [35:0] w_mu;
    logic signed [19:0] w_q;
    logic signed [15:0] w_off;
    logic signed [20:0] w_st;
    logic signed [15:0] n_step;
    logic               n_sat;
    logic               w_en;

    assign w_en = !(r_out_valid && !i_m_ready && r_e3.valid);

    assign n_e1.valid = i_item.valid;
    assign n_e1.mode  = i_item.mode;
    assign n_e1.axis  = i_item.set[1];

    assign w_n  = {r_hk, 16'h0000} + $signed({33'h0, r_lk}) + ROUND_C;
    assign w_m  = w_n[63:28];
    assign w_mc = (w_m > M_HI) ? M_HI : ((w_m < M_LO) ? M_LO : w_m);
    assign w_mu = w_mc + M_BIAS;

    assign w_q   = $signed({1'b0, r_ur[42:24]}) - Q_BIAS;
    assign w_off = r_e3.axis ? i_offset_y : i_offset_x;
    assign w_st  = {w_q[19], w_q} + {{5{w_off[15]}}, w_off};

    always_comb begin
        if (r_e3.mode == MODE_WRITE) begin
            n_step = '0;
            n_sat  = 1'b0;
        end else if (w_st > STEP_HI) begin
            n_step = STEP_HI[15:0];
            n_sat  = 1'b1;
        end else if (w_st < STEP_LO) begin
            n_step = STEP_LO[15:0];
            n_sat  = 1'b1;
        end else begin
            n_step = w_st[15:0];
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1.valid  <= 1'b0;
            r_e2.valid  <= 1'b0;
            r_e3.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_e1 <= n_e1;
                r_e2 <= r_e1;
                r_e3 <= r_e2;
            end
            if (w_en && r_e3.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hk <= $signed(i_item.acc[47:16]) * $signed({1'b0, STEP_K});
            r_lk <= i_item.acc[15:0] * STEP_K;
            r_u  <= w_mu[20:0];
            r_ur <= r_u * DIV_R;
        end
        if (w_en && r_e3.valid) begin
            r_step <= n_step;
            r_sat  <= n_sat;
        end
    end

    assign o_en        = w_en;
    assign o_valid     = r_out_valid;
    assign o_step      = r_step;
    assign o_saturated = r_sat;

endmodule
